// File: hw/rtl/uart_tx_ring_dma_dispatch_unit_macros.svh
// Assertion macros for the transmit ring dispatch unit.
`ifndef UART_TX_RING_DMA_DISPATCH_UNIT_MACROS_SVH
`define UART_TX_RING_DMA_DISPATCH_UNIT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define UTRDD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Check that a condition implies another in the next cycle.
`define UTRDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: sequence");

`endif

// File: hw/rtl/utrdd_pkg.sv
package utrdd_pkg;

    localparam int OUT_W           = 11;
    localparam int QUEUE_DEPTH_DEF = 2048;

    localparam logic [7:0] LINE_FEED       = 8'h0A;
    localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_DONE  = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_LF
    } t_state;

endpackage

// File: hw/rtl/uart_tx_ring_dma_dispatch_unit.sv
// The result strobe rises in the cycle after the item is accepted.
// Throughput: one item per cycle while not busy; a line feed that gets a carriage
// return in front is two writes to the single-port ring memory, busy during the second.
// Reset (synchronous, active low) clears indices, busy flag and auto_crlf;
// ring memory contents stay undefined. Results cannot be stalled.
module uart_tx_ring_dma_dispatch_unit #(
    parameter int QUEUE_DEPTH = utrdd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_of_write,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_accepted,
    output logic                        o_start_valid,
    output logic [utrdd_pkg::OUT_W-1:0] o_start_offset,
    output logic [utrdd_pkg::OUT_W-1:0] o_start_length,
    output logic [utrdd_pkg::OUT_W-1:0] o_queued_count,
    output logic                        o_busy_res
);
    import utrdd_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int LEN_W = IDX_W + 1;
    localparam int SUM_W = LEN_W + 1;
    localparam int EXT_W = (LEN_W > OUT_W) ? LEN_W : OUT_W;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_in_flight, n_in_flight;
    logic [LEN_W-1:0] r_active_len, n_active_len;
    logic [IDX_W-1:0] r_lf_addr, n_lf_addr;
    logic             r_auto_crlf;

    logic [7:0]       r_mem [QUEUE_DEPTH];
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [7:0]       mem_din;

    logic [IDX_W-1:0] w_p1, w_p2;
    logic             full, two_free;
    logic [SUM_W-1:0] rd_sum;
    logic [IDX_W-1:0] rd_wrap;
    logic             do_check, accept, acc, started;
    logic [LEN_W-1:0] avail, held;

    logic [EXT_W-1:0] ext_offset, ext_length, ext_held;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign w_p1     = (r_wr_idx == IDX_LAST) ? '0 : r_wr_idx + 1'b1;
    assign w_p2     = (w_p1 == IDX_LAST) ? '0 : w_p1 + 1'b1;
    assign full     = (w_p1 == r_rd_idx);
    assign two_free = !full && (w_p2 != r_rd_idx);
    assign rd_sum   = SUM_W'(r_rd_idx) + SUM_W'(r_active_len);
    assign rd_wrap  = (rd_sum >= DEPTH_SUM) ? IDX_W'(rd_sum - DEPTH_SUM) : IDX_W'(rd_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_wr_idx     = r_wr_idx;
        n_rd_idx     = r_rd_idx;
        n_in_flight  = r_in_flight;
        n_active_len = r_active_len;
        n_lf_addr    = r_lf_addr;
        mem_we       = 1'b0;
        mem_addr     = r_wr_idx;
        mem_din      = i_data_byte;
        do_check     = 1'b0;
        acc          = 1'b0;
        started      = 1'b0;
        avail        = '0;
        held         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_WRITE) begin
                        if (!full) begin
                            acc    = 1'b1;
                            mem_we = 1'b1;
                            if (r_auto_crlf && (i_data_byte == LINE_FEED) && two_free) begin
                                mem_din   = CARRIAGE_RETURN;
                                n_lf_addr = w_p1;
                                n_wr_idx  = w_p2;
                                n_state   = S_LF;
                            end else begin
                                n_wr_idx = w_p1;
                            end
                        end
                        do_check = i_last_of_write;
                    end else begin
                        n_rd_idx     = rd_wrap;
                        n_active_len = '0;
                        n_in_flight  = 1'b0;
                        do_check     = 1'b1;
                    end
                end
            end
            S_LF: begin
                mem_we   = 1'b1;
                mem_addr = r_lf_addr;
                mem_din  = LINE_FEED;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_wr_idx >= n_rd_idx) begin
            avail = LEN_W'(n_wr_idx) - LEN_W'(n_rd_idx);
        end else begin
            avail = DEPTH_LEN - LEN_W'(n_rd_idx);
        end
        started = do_check && !n_in_flight && (avail != '0);
        if (started) begin
            n_in_flight  = 1'b1;
            n_active_len = avail;
        end
        if (n_wr_idx >= n_rd_idx) begin
            held = LEN_W'(n_wr_idx) - LEN_W'(n_rd_idx);
        end else begin
            held = DEPTH_LEN - (LEN_W'(n_rd_idx) - LEN_W'(n_wr_idx));
        end
    end

    assign ext_offset = started ? EXT_W'(n_rd_idx) : '0;
    assign ext_length = started ? EXT_W'(avail) : '0;
    assign ext_held   = EXT_W'(held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx     <= '0;
            r_rd_idx     <= '0;
            r_in_flight  <= 1'b0;
            r_active_len <= '0;
            r_auto_crlf  <= 1'b0;
            o_strobe     <= 1'b0;
        end else begin
            r_wr_idx     <= n_wr_idx;
            r_rd_idx     <= n_rd_idx;
            r_in_flight  <= n_in_flight;
            r_active_len <= n_active_len;
            o_strobe     <= accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_auto_crlf <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lf_addr <= n_lf_addr;
        if (accept) begin
            o_accepted     <= acc;
            o_start_valid  <= started;
            o_start_offset <= ext_offset[OUT_W-1:0];
            o_start_length <= ext_length[OUT_W-1:0];
            o_queued_count <= ext_held[OUT_W-1:0];
            o_busy_res     <= n_in_flight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_din;
        end
    end

`include "uart_tx_ring_dma_dispatch_unit_macros.svh"

    `UTRDD_ASSERT_NEXT(a_strobe_after_accept, start && !busy, o_strobe)
    `UTRDD_ASSERT_ALWAYS(a_no_segment_zero, !o_strobe || o_start_valid || (o_start_offset == '0 && o_start_length == '0))
    `UTRDD_ASSERT_ALWAYS(a_started_is_busy, !o_strobe || !o_start_valid || o_busy_res)
    `UTRDD_ASSERT_ALWAYS(a_idx_range, (LEN_W'(r_wr_idx) < DEPTH_LEN) && (LEN_W'(r_rd_idx) < DEPTH_LEN))
    `UTRDD_ASSERT_ALWAYS(a_flight_has_len, !r_in_flight || (r_active_len != '0))

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import utrdd_pkg::*;

    typedef struct packed {
        logic             accepted;
        logic             start_valid;
        logic [OUT_W-1:0] start_offset;
        logic [OUT_W-1:0] start_length;
        logic [OUT_W-1:0] queued_count;
        logic             busy_res;
    } t_dispatch_result;

    class ring_dispatch_checker;
        int unsigned      wr_idx;
        int unsigned      rd_idx;
        int unsigned      active_len;
        bit               in_flight;
        bit               crlf;
        int               mismatches;
        t_dispatch_result pending_results[$];

        function new();
            wr_idx     = 0;
            rd_idx     = 0;
            active_len = 0;
            in_flight  = 1'b0;
            crlf       = 1'b0;
            mismatches = 0;
        endfunction

        function int unsigned held();
            return (wr_idx + QUEUE_DEPTH_DEF - rd_idx) % QUEUE_DEPTH_DEF;
        endfunction

        function int unsigned free_slots();
            return QUEUE_DEPTH_DEF - 1 - held();
        endfunction

        function void push_byte();
            wr_idx = (wr_idx + 1) % QUEUE_DEPTH_DEF;
        endfunction

        function void try_start(inout t_dispatch_result r);
            int unsigned avail;
            if (in_flight)
                return;
            avail = (wr_idx >= rd_idx) ? wr_idx - rd_idx : QUEUE_DEPTH_DEF - rd_idx;
            if (avail == 0)
                return;
            if (avail > 32'hFFFF)
                avail = 32'hFFFF;
            in_flight      = 1'b1;
            active_len     = avail;
            r.start_valid  = 1'b1;
            r.start_offset = OUT_W'(rd_idx);
            r.start_length = OUT_W'(avail);
        endfunction

        function void note_item(bit f, logic [7:0] b, bit last);
            t_dispatch_result r;
            r = '0;
            if (f == FUNC_WRITE) begin
                if (free_slots() > 0) begin
                    r.accepted = 1'b1;
                    if (crlf && b == LINE_FEED && free_slots() >= 2)
                        push_byte();
                    push_byte();
                end
                if (last)
                    try_start(r);
            end else begin
                if (active_len != 0) begin
                    rd_idx     = (rd_idx + active_len) % QUEUE_DEPTH_DEF;
                    active_len = 0;
                end
                in_flight = 1'b0;
                try_start(r);
            end
            r.queued_count = OUT_W'(held());
            r.busy_res     = in_flight;
            pending_results.push_back(r);
        endfunction

        function string show(t_dispatch_result r);
            return $sformatf("acc=%0d start=%0d off=%0d len=%0d count=%0d busy=%0d",
                             r.accepted, r.start_valid, r.start_offset,
                             r.start_length, r.queued_count, r.busy_res);
        endfunction

        function void check_result(t_dispatch_result got);
            t_dispatch_result exp_r;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: %s", $realtime, show(got));
                return;
            end
            exp_r = pending_results.pop_front();
            if (exp_r !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected %s, got %s",
                             $realtime, show(exp_r), show(got));
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             func;
    logic [7:0]       data_byte;
    logic             last_of_write;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_data;
    logic             o_strobe;
    logic             o_accepted;
    logic             o_start_valid;
    logic [OUT_W-1:0] o_start_offset;
    logic [OUT_W-1:0] o_start_length;
    logic [OUT_W-1:0] o_queued_count;
    logic             o_busy_res;

    ring_dispatch_checker chk = new();
    bit                   idle_on = 1'b1;

    uart_tx_ring_dma_dispatch_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (func),
        .i_data_byte     (data_byte),
        .i_last_of_write (last_of_write),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_strobe        (o_strobe),
        .o_accepted      (o_accepted),
        .o_start_valid   (o_start_valid),
        .o_start_offset  (o_start_offset),
        .o_start_length  (o_start_length),
        .o_queued_count  (o_queued_count),
        .o_busy_res      (o_busy_res)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            chk.check_result({o_accepted, o_start_valid, o_start_offset,
                              o_start_length, o_queued_count, o_busy_res});
    end

    task automatic send_item(bit f, logic [7:0] b, bit last);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        func          = f;
        data_byte     = b;
        last_of_write = last;
        start         = 1'b1;
        do @(posedge i_clk); while (busy);
        chk.note_item(f, b, last);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (chk.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_crlf(bit v);
        drain_results();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge i_clk); while (!cfg_ready);
        chk.crlf = v;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return LINE_FEED;
            1: return CARRIAGE_RETURN;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_traffic(int n, int cpl_pct, int max_burst);
        int  sent;
        int  len;
        bit  last;
        sent = 0;
        while (sent < n) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < cpl_pct) begin
                send_item(FUNC_DONE, 8'($urandom), 1'($urandom));
                sent++;
            end else begin
                len = $urandom_range(1, max_burst);
                for (int i = 0; i < len; i++) begin
                    if (i == len - 1)
                        last = ($urandom_range(0, 9) != 0);
                    else
                        last = ($urandom_range(0, 29) == 0);
                    send_item(FUNC_WRITE, pick_byte(), last);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        func          = FUNC_WRITE;
        data_byte     = 8'h00;
        last_of_write = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(FUNC_DONE, 8'h00, 1'b0);
        send_item(FUNC_WRITE, 8'h00, 1'b0);
        send_item(FUNC_WRITE, 8'hFF, 1'b1);
        send_item(FUNC_WRITE, LINE_FEED, 1'b1);
        send_item(FUNC_WRITE, 8'h80, 1'b0);
        send_item(FUNC_DONE, 8'h00, 1'b0);
        send_item(FUNC_DONE, 8'hFF, 1'b1);
        send_item(FUNC_DONE, 8'h00, 1'b0);
        write_crlf(1'b1);
        send_item(FUNC_WRITE, LINE_FEED, 1'b1);
        send_item(FUNC_WRITE, CARRIAGE_RETURN, 1'b1);
        send_item(FUNC_WRITE, 8'h01, 1'b0);
        send_item(FUNC_DONE, 8'hAA, 1'b1);
        send_item(FUNC_DONE, 8'h7F, 1'b0);
        send_item(FUNC_DONE, 8'h55, 1'b1);

        // fill the ring, then a line feed with one slot left, then drops
        while (chk.free_slots() > 2)
            send_item(FUNC_WRITE, LINE_FEED, 1'b0);
        while (chk.free_slots() > 1)
            send_item(FUNC_WRITE, 8'($urandom_range(11, 255)), 1'b0);
        send_item(FUNC_WRITE, LINE_FEED, 1'b0);
        send_item(FUNC_WRITE, 8'hFF, 1'b1);
        send_item(FUNC_WRITE, LINE_FEED, 1'b1);
        while (chk.held() != 0 || chk.in_flight)
            send_item(FUNC_DONE, 8'($urandom), 1'($urandom));

        for (int ph = 0; ph < 4; ph++) begin
            write_crlf(ph == 1 || ph == 2);
            case (ph)
                0: run_traffic(190, 12, 24);
                1: run_traffic(190, 2, 120);
                2: run_traffic(190, 30, 8);
                default: run_traffic(190, 6, 60);
            endcase
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
